// ===== rtl/utcr_pkg.sv =====
// ----------------------------------------------------------------------------
// utcr_pkg: shared types and constants for the UART transmit capture ring
// Command codes, controller state and the controller/datapath interfaces.
// ----------------------------------------------------------------------------
package utcr_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_DRAIN = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_FETCH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic load_now;
		logic load_fetch;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic pop;
	} status_t;

	localparam logic [7:0] STATUS_TX_READY = 8'h01;
	localparam int         CTRL_ENABLE_BIT = 0;

endpackage

// ===== rtl/uart_tx_capture_ring.sv =====
// A read, write, clear or empty drain word gives its result in the cycle after acceptance;
// a drain that pops a byte gives it through the registered store read and then the result register.
// Throughput: one word per cycle while results are taken; a popping drain holds off the next word during its fetch.
// Reset clears control, pointers, fill count and result valid; store contents stay undefined.
// ----------------------------------------------------------------------------
// uart_tx_capture_ring: UART transmit capture block
// Bus register access with a ring buffer of transmitted bytes that overwrites
// the oldest byte when full, drained one byte per word by the host.
// ----------------------------------------------------------------------------
module uart_tx_capture_ring #(
	parameter int BUF_DEPTH      = 256,
	parameter int DATA_OFFSET    = 0,
	parameter int STATUS_OFFSET  = 4,
	parameter int CONTROL_OFFSET = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [3:0]  bus_offset,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [7:0]  drained_byte,
	output logic        drained_valid,
	output logic [8:0]  stored_count
);
	import utcr_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	utcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.ctrl     (ctrl)
	);

	utcr_dp #(
		.BUF_DEPTH     (BUF_DEPTH),
		.DATA_OFFSET   (DATA_OFFSET),
		.STATUS_OFFSET (STATUS_OFFSET),
		.CONTROL_OFFSET(CONTROL_OFFSET)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.bus_offset   (bus_offset),
		.write_data   (write_data),
		.ctrl         (ctrl),
		.status       (status),
		.read_data    (read_data),
		.drained_byte (drained_byte),
		.drained_valid(drained_valid),
		.stored_count (stored_count)
	);

endmodule

// ===== rtl/utcr_ram.sv =====
// ----------------------------------------------------------------------------
// utcr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module utcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/utcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// utcr_ctrl: handshake controller
// Accepts words, holds the result valid flag and sequences the RAM fetch of
// a drain that pops a byte.
// ----------------------------------------------------------------------------
module utcr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  utcr_pkg::status_t status,
	output utcr_pkg::ctrl_t   ctrl
);
	import utcr_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.accept && status.pop) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
		ctrl.accept     = in_valid && in_ready;
		ctrl.load_now   = ctrl.accept && !status.pop;
		ctrl.load_fetch = (state_q == ST_FETCH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load_now || ctrl.load_fetch) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/utcr_dp.sv =====
// ----------------------------------------------------------------------------
// utcr_dp: capture ring datapath
// Control register, ring pointers, fill count, byte store and result register.
// ----------------------------------------------------------------------------
module utcr_dp #(
	parameter int BUF_DEPTH      = 256,
	parameter int DATA_OFFSET    = 0,
	parameter int STATUS_OFFSET  = 4,
	parameter int CONTROL_OFFSET = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        command,
	input  logic [3:0]        bus_offset,
	input  logic [31:0]       write_data,
	input  utcr_pkg::ctrl_t   ctrl,
	output utcr_pkg::status_t status,
	output logic [7:0]        read_data,
	output logic [7:0]        drained_byte,
	output logic              drained_valid,
	output logic [8:0]        stored_count
);
	import utcr_pkg::*;

	localparam int PTR_W = $clog2(BUF_DEPTH);
	localparam int CNT_W = $clog2(BUF_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUF_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUF_DEPTH);

	logic [7:0]       control_q;
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [PTR_W-1:0] wr_ptr_nxt, rd_ptr_nxt;
	logic [7:0]       rd_val;
	logic             hit_data, hit_status, hit_control;
	logic             store_we;
	logic [7:0]       ram_rdata;
	cmd_t             cmd;

	logic [7:0] read_data_q, drained_byte_q;
	logic       drained_valid_q;
	logic [8:0] stored_count_q;

	assign cmd         = cmd_t'(command);
	assign hit_data    = (bus_offset == 4'(DATA_OFFSET));
	assign hit_status  = (bus_offset == 4'(STATUS_OFFSET));
	assign hit_control = (bus_offset == 4'(CONTROL_OFFSET));
	assign wr_ptr_nxt  = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_nxt  = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign status.pop  = (cmd == CMD_DRAIN) && (cnt_q != '0);
	assign store_we    = ctrl.accept && (cmd == CMD_WRITE) && hit_data
		&& control_q[CTRL_ENABLE_BIT];

	always_comb begin
		rd_val = 8'h00;
		if (hit_data) begin
			rd_val = 8'h00;
		end else if (hit_status) begin
			rd_val = STATUS_TX_READY;
		end else if (hit_control) begin
			rd_val = control_q;
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		case (cmd)
			CMD_WRITE: if (store_we && cnt_q != CNT_FULL) cnt_d = cnt_q + 1'b1;
			CMD_DRAIN: if (status.pop) cnt_d = cnt_q - 1'b1;
			CMD_CLEAR: cnt_d = '0;
			default:   cnt_d = cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
		end else if (ctrl.accept) begin
			cnt_q <= cnt_d;
			case (cmd)
				CMD_WRITE: begin
					if (store_we) begin
						wr_ptr_q <= wr_ptr_nxt;
						if (cnt_q == CNT_FULL) rd_ptr_q <= rd_ptr_nxt;
					end else if (!hit_data && hit_control) begin
						control_q <= write_data[7:0];
					end
				end
				CMD_DRAIN: if (status.pop) rd_ptr_q <= rd_ptr_nxt;
				CMD_CLEAR: begin
					wr_ptr_q <= '0;
					rd_ptr_q <= '0;
				end
				default: ;
			endcase
		end
	end

	utcr_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(wr_ptr_q),
		.wdata(write_data[7:0]),
		.re   (ctrl.accept && status.pop),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctrl.load_now) begin
			read_data_q     <= (cmd == CMD_READ) ? rd_val : 8'h00;
			drained_byte_q  <= 8'h00;
			drained_valid_q <= 1'b0;
			stored_count_q  <= 9'(cnt_d);
		end else if (ctrl.load_fetch) begin
			read_data_q     <= 8'h00;
			drained_byte_q  <= ram_rdata;
			drained_valid_q <= 1'b1;
			stored_count_q  <= 9'(cnt_q);
		end
	end

	assign read_data     = read_data_q;
	assign drained_byte  = drained_byte_q;
	assign drained_valid = drained_valid_q;
	assign stored_count  = stored_count_q;

endmodule

// ===== rtl/utcr_checker.sv =====
// ----------------------------------------------------------------------------
// utcr_checker: port-level checks for the UART transmit capture ring
// Bound to the top level; watches handshakes and result words.
// ----------------------------------------------------------------------------
module utcr_checker #(
	parameter int DATA_OFFSET   = 0,
	parameter int STATUS_OFFSET = 4
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  command,
	input logic [3:0]  bus_offset,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  read_data,
	input logic [7:0]  drained_byte,
	input logic        drained_valid,
	input logic [8:0]  stored_count
);
	import utcr_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)
			&& $stable(drained_byte) && $stable(drained_valid) && $stable(stored_count))
		else $error("result word changed while stalled");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && command == CMD_CLEAR |=> out_valid && stored_count == 9'd0
			&& !drained_valid)
		else $error("clear did not report an empty ring");

	a_status_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && command == CMD_READ && bus_offset == 4'(STATUS_OFFSET)
			&& bus_offset != 4'(DATA_OFFSET) |=> out_valid && read_data == STATUS_TX_READY)
		else $error("status read did not return ready");

	a_drain_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drained_valid |-> read_data == 8'h00)
		else $error("drained byte came with nonzero read data");

endmodule

bind uart_tx_capture_ring utcr_checker #(
	.DATA_OFFSET  (DATA_OFFSET),
	.STATUS_OFFSET(STATUS_OFFSET)
) u_utcr_checker (.*);
